[hw/rtl/awl_pkg.sv]
// Shared types, constants and helpers for the activation window limiter.
package awl_pkg;

  localparam int TimeW      = 64;
  localparam int WinW       = 16;
  localparam int RankFieldW = 2;
  localparam int CfgIdxW    = 2;

  localparam int FourDepth = 4;
  localparam int FourPtrW  = 2;
  localparam int FourCntW  = 3;
  localparam int WideDepth = 32;
  localparam int WidePtrW  = 5;
  localparam int WideCntW  = 6;

  localparam logic [WinW-1:0] FourWinReset = 16'd32;
  localparam logic [WinW-1:0] WideWinReset = 16'd320;

  typedef enum logic [CfgIdxW-1:0] {
    RegFourWin = 2'd0,
    RegWideWin = 2'd1,
    RegGddr    = 2'd2
  } cfg_reg_e;

  // Outcome of one queue evaluation; pointers and counts sized for the
  // deeper queue, the four-entry queue uses the low bits.
  typedef struct packed {
    logic                blocks;
    logic                wr_en;
    logic                ovf;
    logic [WidePtrW-1:0] head_nx;
    logic [WideCntW-1:0] cnt_nx;
    logic [WidePtrW-1:0] wr_ptr;
    logic [TimeW-1:0]    wr_data;
  } q_upd_t;

  // time + window, clamped at all ones
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] t,
                                               input logic [WinW-1:0] w);
    logic [TimeW:0] s;
    s = {1'b0, t} + {{(TimeW + 1 - WinW){1'b0}}, w};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage

[hw/rtl/activation_window_limiter_core.sv]
// Top level of the per-rank rolling activation window limiter (four and 32 activations).
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+-------------------------------
//  s_axis  | in        | tvalid tready tdata tuser        | tuser: operation;
//          |           |                                  | tdata: rank, current_time
//  m_axis  | out       | tvalid tready tdata              | tdata: window_ok, overflow
//  cfg     | in        | cfg_valid/ready, index, data     | 0 four window, 1 wide, 2 gddr
//
// One transaction per cycle while m_axis does not stall. Accepting an input registers it
// into the evaluation stage and launches the expiry store reads; when that stage fires, it
// evaluates both queues, updates rank state and loads the result register.
// Head/count updates of the rank in evaluation feed the next read; stores bypass writes.
// Reset clears heads, counts and valids and loads the default windows; expiry stores need no clear.
// A stall on m_axis holds the evaluation stage, which then holds s_axis.
module activation_window_limiter_core #(
  parameter int RANKS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [71:0]                 s_axis_tdata,   // [1:0] rank, [65:2] current_time
  input  logic                        s_axis_tuser,   // [0] operation

  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [0] window_ok, [1] overflow

  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [awl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [awl_pkg::WinW-1:0]    cfg_data_i
);

  localparam int RankW     = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int FourAddrW = RankW + awl_pkg::FourPtrW;
  localparam int WideAddrW = RankW + awl_pkg::WidePtrW;

  // ---------------- configuration ----------------
  logic [awl_pkg::WinW-1:0] four_win_q;
  logic [awl_pkg::WinW-1:0] wide_win_q;
  logic                     gddr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_win_q <= awl_pkg::FourWinReset;
      wide_win_q <= awl_pkg::WideWinReset;
      gddr_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      case (awl_pkg::cfg_reg_e'(cfg_index_i))
        awl_pkg::RegFourWin: four_win_q <= cfg_data_i;
        awl_pkg::RegWideWin: wide_win_q <= cfg_data_i;
        awl_pkg::RegGddr:    gddr_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- input unpack ----------------
  logic                             in_op;
  logic [awl_pkg::RankFieldW-1:0]   in_rank;
  logic [awl_pkg::TimeW-1:0]        in_time;
  logic [RankW-1:0]                 in_idx;
  logic                             in_rank_ok;
  logic                             in_acc;

  assign in_op      = s_axis_tuser;
  assign in_rank    = s_axis_tdata[1:0];
  assign in_time    = s_axis_tdata[65:2];
  assign in_idx     = RankW'(in_rank);
  assign in_rank_ok = (32'(in_rank) < RANKS);

  // ---------------- per-rank queue pointers ----------------
  logic [awl_pkg::FourPtrW-1:0] four_hp_q  [RANKS];
  logic [awl_pkg::FourCntW-1:0] four_cnt_q [RANKS];
  logic [awl_pkg::WidePtrW-1:0] wide_hp_q  [RANKS];
  logic [awl_pkg::WideCntW-1:0] wide_cnt_q [RANKS];

  // ---------------- evaluation stage ----------------
  logic                         s1_valid_q;
  logic                         s1_op_q;
  logic                         s1_rank_ok_q;
  logic [RankW-1:0]             s1_idx_q;
  logic [awl_pkg::TimeW-1:0]    s1_time_q;
  logic [awl_pkg::FourPtrW-1:0] s1_fhp_q;
  logic [awl_pkg::FourCntW-1:0] s1_fcnt_q;
  logic [awl_pkg::WidePtrW-1:0] s1_whp_q;
  logic [awl_pkg::WideCntW-1:0] s1_wcnt_q;

  logic                         m_valid_q;
  logic                         m_ok_q;
  logic                         m_ovf_q;

  logic                         out_free;
  logic                         s1_fire;
  logic                         upd_en;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign upd_en        = s1_fire && s1_rank_ok_q;

  logic [awl_pkg::TimeW-1:0] four_head_val;
  logic [awl_pkg::TimeW-1:0] wide_head_val;
  awl_pkg::q_upd_t           four_upd;
  awl_pkg::q_upd_t           wide_upd;

  awl_queue_step #(
    .Depth(awl_pkg::FourDepth)
  ) u_four_step (
    .head_ptr_i (s1_fhp_q),
    .count_i    (s1_fcnt_q),
    .head_val_i (four_head_val),
    .time_i     (s1_time_q),
    .window_i   (four_win_q),
    .record_i   (s1_op_q),
    .upd_o      (four_upd)
  );

  awl_queue_step #(
    .Depth(awl_pkg::WideDepth)
  ) u_wide_step (
    .head_ptr_i (s1_whp_q),
    .count_i    (s1_wcnt_q),
    .head_val_i (wide_head_val),
    .time_i     (s1_time_q),
    .window_i   (wide_win_q),
    .record_i   (s1_op_q && gddr_q),
    .upd_o      (wide_upd)
  );

  // Pointers the incoming transaction sees: the rank being evaluated passes its
  // updated head/count straight across.
  logic                         fwd_hit;
  logic [awl_pkg::FourPtrW-1:0] fwd_fhp;
  logic [awl_pkg::FourCntW-1:0] fwd_fcnt;
  logic [awl_pkg::WidePtrW-1:0] fwd_whp;
  logic [awl_pkg::WideCntW-1:0] fwd_wcnt;

  always_comb begin
    fwd_hit = upd_en && (s1_idx_q == in_idx);
    if (fwd_hit) begin
      fwd_fhp  = four_upd.head_nx[awl_pkg::FourPtrW-1:0];
      fwd_fcnt = four_upd.cnt_nx[awl_pkg::FourCntW-1:0];
      fwd_whp  = wide_upd.head_nx;
      fwd_wcnt = wide_upd.cnt_nx;
    end else begin
      fwd_fhp  = four_hp_q[in_idx];
      fwd_fcnt = four_cnt_q[in_idx];
      fwd_whp  = wide_hp_q[in_idx];
      fwd_wcnt = wide_cnt_q[in_idx];
    end
  end

  // ---------------- expiry stores ----------------
  awl_expiry_mem #(
    .Entries (RANKS * awl_pkg::FourDepth),
    .AddrW   (FourAddrW)
  ) u_four_mem (
    .clk_i     (clk_i),
    .wr_en_i   (upd_en && four_upd.wr_en),
    .wr_addr_i ({s1_idx_q, four_upd.wr_ptr[awl_pkg::FourPtrW-1:0]}),
    .wr_data_i (four_upd.wr_data),
    .rd_en_i   (in_acc),
    .rd_addr_i ({in_idx, fwd_fhp}),
    .rd_data_o (four_head_val)
  );

  awl_expiry_mem #(
    .Entries (RANKS * awl_pkg::WideDepth),
    .AddrW   (WideAddrW)
  ) u_wide_mem (
    .clk_i     (clk_i),
    .wr_en_i   (upd_en && wide_upd.wr_en),
    .wr_addr_i ({s1_idx_q, wide_upd.wr_ptr}),
    .wr_data_i (wide_upd.wr_data),
    .rd_en_i   (in_acc),
    .rd_addr_i ({in_idx, fwd_whp}),
    .rd_data_o (wide_head_val)
  );

  // ---------------- rank state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RANKS; r++) begin
        four_hp_q[r]  <= '0;
        four_cnt_q[r] <= '0;
        wide_hp_q[r]  <= '0;
        wide_cnt_q[r] <= '0;
      end
    end else if (upd_en) begin
      four_hp_q[s1_idx_q]  <= four_upd.head_nx[awl_pkg::FourPtrW-1:0];
      four_cnt_q[s1_idx_q] <= four_upd.cnt_nx[awl_pkg::FourCntW-1:0];
      wide_hp_q[s1_idx_q]  <= wide_upd.head_nx;
      wide_cnt_q[s1_idx_q] <= wide_upd.cnt_nx;
    end
  end

  // ---------------- stage registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q      <= in_op;
      s1_rank_ok_q <= in_rank_ok;
      s1_idx_q     <= in_idx;
      s1_time_q    <= in_time;
      s1_fhp_q     <= fwd_fhp;
      s1_fcnt_q    <= fwd_fcnt;
      s1_whp_q     <= fwd_whp;
      s1_wcnt_q    <= fwd_wcnt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= s1_valid_q;
    end
  end

  // out-of-range rank: always ok, never overflow
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      m_ok_q  <= !s1_rank_ok_q ||
                 !(four_upd.blocks || (gddr_q && wide_upd.blocks));
      m_ovf_q <= s1_rank_ok_q && (four_upd.ovf || (gddr_q && wide_upd.ovf));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_ovf_q, m_ok_q};

endmodule

[hw/rtl/awl_expiry_mem.sv]
// Expiry time store: one write port, one registered read port with write bypass.
module awl_expiry_mem #(
  parameter int Entries = 16,
  parameter int AddrW   = 4
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [awl_pkg::TimeW-1:0]  wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [awl_pkg::TimeW-1:0]  rd_data_o
);

  logic [awl_pkg::TimeW-1:0] mem_q [Entries];
  logic [awl_pkg::TimeW-1:0] rd_q;
  logic [awl_pkg::TimeW-1:0] byp_data_q;
  logic                      byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // a read that lands on the entry written in the same cycle takes the new data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      byp_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

[hw/rtl/awl_queue_step.sv]
// Check and record logic for one rank's expiry queue.
module awl_queue_step #(
  parameter int Depth = 4
) (
  input  logic [$clog2(Depth)-1:0]  head_ptr_i,
  input  logic [$clog2(Depth):0]    count_i,
  input  logic [awl_pkg::TimeW-1:0] head_val_i,
  input  logic [awl_pkg::TimeW-1:0] time_i,
  input  logic [awl_pkg::WinW-1:0]  window_i,
  input  logic                      record_i,
  output awl_pkg::q_upd_t           upd_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = PtrW + 1;
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);

  logic            full;
  logic            expired;
  logic            pop;
  logic [CntW-1:0] c0;
  logic [CntW-1:0] c1;
  logic [PtrW-1:0] h1;
  logic [PtrW-1:0] head_nx;
  logic [PtrW-1:0] wr_ptr;
  logic [CntW-1:0] cnt_nx;
  logic            ovf;

  always_comb begin
    full    = (count_i >= DepthC);
    c0      = full ? DepthC : count_i;
    expired = (time_i >= head_val_i);
    pop     = (c0 != '0) && expired;
    h1      = pop ? head_ptr_i + 1'b1 : head_ptr_i;
    c1      = pop ? c0 - 1'b1 : c0;
    if (c1 == DepthC) begin
      // still full: newest replaces oldest
      wr_ptr  = h1;
      head_nx = h1 + 1'b1;
      cnt_nx  = DepthC;
      ovf     = 1'b1;
    end else begin
      wr_ptr  = h1 + c1[PtrW-1:0];
      head_nx = h1;
      cnt_nx  = c1 + 1'b1;
      ovf     = 1'b0;
    end

    upd_o.blocks  = full && !expired;
    upd_o.wr_en   = record_i;
    upd_o.ovf     = record_i && ovf;
    upd_o.head_nx = (awl_pkg::WidePtrW)'(record_i ? head_nx : head_ptr_i);
    upd_o.cnt_nx  = (awl_pkg::WideCntW)'(record_i ? cnt_nx : count_i);
    upd_o.wr_ptr  = (awl_pkg::WidePtrW)'(wr_ptr);
    upd_o.wr_data = awl_pkg::sat_add(time_i, window_i);
  end

endmodule

[tb/tb_activation_window_limiter_core.sv]
// Self-checking testbench for the per-rank rolling activation window limiter.
module tb_activation_window_limiter_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TimeW     = awl_pkg::TimeW;
  localparam int WinW      = awl_pkg::WinW;
  localparam int CfgIdxW   = awl_pkg::CfgIdxW;
  localparam int FourDepth = awl_pkg::FourDepth;
  localparam int WideDepth = awl_pkg::WideDepth;

  localparam int NumRanks  = 4;
  localparam int IdleLimit = 3000;  // cycles without any transaction
  localparam int ShowLimit = 50;    // mismatch lines printed before going quiet

  typedef enum logic {
    OpCheck  = 1'b0,
    OpRecord = 1'b1
  } act_op_e;

  typedef enum bit {
    KindFour = 1'b0,
    KindWide = 1'b1
  } window_kind_e;

  typedef struct packed {
    logic ok;
    logic ovf;
  } verdict_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata;   // [1:0] rank, [65:2] current_time
  logic               s_axis_tuser;   // [0] operation
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;   // [0] window_ok, [1] overflow
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [WinW-1:0]    cfg_data_i;

  activation_window_limiter_core #(
    .RANKS(NumRanks)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Mirror of the limiter: configuration and per-rank expiry rings.
  logic [WinW-1:0]  win_four;
  logic [WinW-1:0]  win_wide;
  bit               gddr_on;
  logic [TimeW-1:0] act_slot [2][NumRanks][WideDepth];
  int               act_head [2][NumRanks];
  int               act_fill [2][NumRanks];

  verdict_t         pending_verdicts[$];
  verdict_t         seen_want;
  int               mismatches;
  int               idle_cycles;
  int               burst_left;
  bit               eager_sender;
  int               hold_off_cycles;
  int               ready_mode;
  int               mode_left;
  logic [TimeW-1:0] sim_cycle;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int ring_depth(window_kind_e kind);
    return (kind == KindWide) ? WideDepth : FourDepth;
  endfunction

  function automatic logic [TimeW-1:0] expiry_of(logic [TimeW-1:0] t,
                                                 logic [WinW-1:0] w);
    logic [TimeW:0] sum;
    sum = {1'b0, t} + {{(TimeW + 1 - WinW){1'b0}}, w};
    return sum[TimeW] ? {TimeW{1'b1}} : sum[TimeW-1:0];
  endfunction

  // A full ring whose oldest entry still lies ahead of t refuses an activation.
  function automatic bit window_closed(window_kind_e kind, int r, logic [TimeW-1:0] t);
    if (act_fill[kind][r] < ring_depth(kind)) return 1'b0;
    return t < act_slot[kind][r][act_head[kind][r]];
  endfunction

  // Drop an expired oldest entry, then append; a still-full ring overwrites its oldest.
  function automatic bit log_activation(window_kind_e kind, int r, logic [TimeW-1:0] t,
                                        logic [TimeW-1:0] expiry);
    int d;
    int h;
    int c;
    d = ring_depth(kind);
    h = act_head[kind][r];
    c = act_fill[kind][r];
    if (c > 0 && t >= act_slot[kind][r][h]) begin
      h = (h + 1) % d;
      c--;
    end
    if (c == d) begin
      act_slot[kind][r][h] = expiry;
      act_head[kind][r]    = (h + 1) % d;
      act_fill[kind][r]    = c;
      return 1'b1;
    end
    act_slot[kind][r][(h + c) % d] = expiry;
    act_head[kind][r] = h;
    act_fill[kind][r] = c + 1;
    return 1'b0;
  endfunction

  function automatic verdict_t predict_activation(act_op_e op, logic [1:0] rank,
                                                  logic [TimeW-1:0] t);
    verdict_t v;
    int r;
    r     = int'(rank);
    v.ok  = 1'b1;
    v.ovf = 1'b0;
    if (window_closed(KindFour, r, t)) v.ok = 1'b0;
    if (gddr_on && window_closed(KindWide, r, t)) v.ok = 1'b0;
    if (op == OpRecord) begin
      v.ovf = log_activation(KindFour, r, t, expiry_of(t, win_four));
      if (gddr_on) v.ovf = v.ovf | log_activation(KindWide, r, t, expiry_of(t, win_wide));
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [TimeW-1:0] got, logic [TimeW-1:0] want);
    if (mismatches < ShowLimit)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Sender: bursts of random length, random gaps between bursts.
  task automatic send_activation(act_op_e op, logic [1:0] rank, logic [TimeW-1:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = (eager_sender || $urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, t, rank};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.insert(pending_verdicts.size(), predict_activation(op, rank, t));
  endtask

  // Mostly a rolling clock with small steps and mostly records; some stale
  // checks and some items with fully random times.
  task automatic send_random_activation(int max_step);
    int               pick;
    logic [1:0]       rank;
    logic [TimeW-1:0] t;
    act_op_e          op;
    pick = $urandom_range(0, 99);
    rank = 2'($urandom_range(0, NumRanks - 1));
    if (pick < 2) sim_cycle = {$urandom, $urandom};
    else if (pick < 3) sim_cycle = {TimeW{1'b1}} - $urandom_range(0, 600);
    sim_cycle = sim_cycle + $urandom_range(0, max_step);
    if (pick < 80) begin
      t  = sim_cycle;
      op = ($urandom_range(0, 9) < 7) ? OpRecord : OpCheck;
    end else if (pick < 92) begin
      t  = sim_cycle - $urandom_range(0, 64);
      op = OpCheck;
    end else begin
      t  = {$urandom, $urandom};
      op = act_op_e'($urandom_range(0, 1));
    end
    send_activation(op, rank, t);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_cfg_accept();
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_windows(logic [WinW-1:0] four, logic [WinW-1:0] wide, bit gddr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= awl_pkg::RegFourWin;
    cfg_data_i  <= four;
    wait_cfg_accept();
    cfg_index_i <= awl_pkg::RegWideWin;
    cfg_data_i  <= wide;
    wait_cfg_accept();
    cfg_index_i <= awl_pkg::RegGddr;
    cfg_data_i  <= {{(WinW - 1){1'b0}}, gddr};
    wait_cfg_accept();
    cfg_valid_i <= 1'b0;
    win_four = four;
    win_wide = wide;
    gddr_on  = gddr;
  endtask

  // Reset windows: fill a rank, overflow it, block and release, extremes of time.
  task automatic test_fill_and_overflow();
    send_activation(OpCheck, 2'd0, 64'd0);
    send_activation(OpRecord, 2'd0, 64'd0);
    send_activation(OpRecord, 2'd0, 64'd1);
    send_activation(OpRecord, 2'd0, 64'd2);
    send_activation(OpRecord, 2'd0, 64'd3);
    send_activation(OpRecord, 2'd0, 64'd4);     // full and unexpired: overwrite
    send_activation(OpCheck, 2'd0, 64'd10);     // blocked
    send_activation(OpCheck, 2'd0, 64'd33);     // oldest expires exactly now
    send_activation(OpRecord, 2'd0, 64'd200);
    send_activation(OpRecord, 2'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_activation(OpCheck, 2'd2, 64'h5555_5555_5555_5555);
    // expiry clamps to all ones near the top of the time range
    repeat (4) send_activation(OpRecord, 2'd3, {TimeW{1'b1}} - 64'd5);
    send_activation(OpCheck, 2'd3, {TimeW{1'b1}} - 64'd1);
    send_activation(OpCheck, 2'd3, {TimeW{1'b1}});
    send_activation(OpRecord, 2'd3, {TimeW{1'b1}});
    quiesce();
  endtask

  // Zero windows: every entry is stale at once, nothing can ever block.
  task automatic test_zero_window();
    program_windows('0, '0, 1'b1);
    repeat (5) send_activation(OpRecord, 2'd2, 64'd7);
    send_activation(OpCheck, 2'd2, 64'd7);
    send_activation(OpRecord, 2'd1, {TimeW{1'b1}});
    quiesce();
  endtask

  task automatic test_random_stream(logic [WinW-1:0] four, logic [WinW-1:0] wide, bit gddr,
                                    int items, int max_step);
    program_windows(four, wide, gddr);
    repeat (items) send_random_activation(max_step);
    quiesce();
  endtask

  // Long receiver hold-off while the sender keeps offering back to back.
  task automatic test_backpressure();
    program_windows(16'd16, 16'd160, 1'b1);
    eager_sender    = 1'b1;
    hold_off_cycles = 120;
    repeat (100) send_random_activation(2);
    eager_sender = 1'b0;
    quiesce();
  endtask

  // Receiver: stall pattern switches between modes, with forced hold-offs.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 150);
        end
        mode_left--;
        case (ready_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Result checker: oldest expectation against each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(m_axis_tdata), '0);
      end else begin
        seen_want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== seen_want.ok)
          report_mismatch("window_ok", 64'(m_axis_tdata[0]), 64'(seen_want.ok));
        if (m_axis_tdata[1] !== seen_want.ovf)
          report_mismatch("overflow", 64'(m_axis_tdata[1]), 64'(seen_want.ovf));
      end
    end
  end

  // Watchdog: too long without any transaction on any channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= awl_pkg::RegFourWin;
    cfg_data_i      <= '0;
    win_four        = awl_pkg::FourWinReset;
    win_wide        = awl_pkg::WideWinReset;
    gddr_on         = 1'b0;
    act_head        = '{default: '{default: 0}};
    act_fill        = '{default: '{default: 0}};
    mismatches      = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    eager_sender    = 1'b0;
    hold_off_cycles = 0;
    ready_mode      = 0;
    mode_left       = 0;
    sim_cycle       = 64'd1000;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fill_and_overflow();
    test_zero_window();
    test_random_stream(16'd32, 16'd320, 1'b1, 300, 3);
    test_random_stream(16'd32, 16'd320, 1'b0, 150, 3);
    test_random_stream(16'd8, 16'd100, 1'b1, 200, 1);
    test_random_stream(16'hFFFF, 16'hFFFF, 1'b1, 150, 10);
    test_random_stream('0, '0, 1'b1, 100, 3);
    test_random_stream(16'($urandom_range(0, 400)), 16'($urandom_range(0, 800)), 1'b1, 150, 3);
    test_random_stream(16'($urandom_range(0, 64)), 16'($urandom_range(0, 400)), 1'b1, 150, 2);
    test_backpressure();
    test_random_stream(16'd32, 16'd320, 1'b1, 50, 3);

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
